// ===== sv/lsffe_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the LED strip fill frame encoder.
// Used by lsffe_cfg, lsffe_core and the top level; depends on nothing.
package lsffe_pkg;

    // Widths of the register fields and the configuration port
    localparam int unsigned TICK_W  = 12;
    localparam int unsigned LED_W   = 8;
    localparam int unsigned DATA_W  = 12;
    localparam int unsigned INDEX_W = 3;
    // Width used for byte position compares (covers 3 * 1023 LEDs)
    localparam int unsigned CMP_W   = 13;

    // Register indexes
    localparam logic [INDEX_W-1:0] REG_ZERO_ACTIVE = 3'd0;
    localparam logic [INDEX_W-1:0] REG_ZERO_IDLE   = 3'd1;
    localparam logic [INDEX_W-1:0] REG_ONE_ACTIVE  = 3'd2;
    localparam logic [INDEX_W-1:0] REG_ONE_IDLE    = 3'd3;
    localparam logic [INDEX_W-1:0] REG_LED_COUNT   = 3'd4;
    localparam logic [INDEX_W-1:0] REG_PIN_INVERT  = 3'd5;

    // Reset values
    localparam logic [TICK_W-1:0] RST_ZERO_ACTIVE = 12'd8;
    localparam logic [TICK_W-1:0] RST_ZERO_IDLE   = 12'd46;
    localparam logic [TICK_W-1:0] RST_ONE_ACTIVE  = 12'd25;
    localparam logic [TICK_W-1:0] RST_ONE_IDLE    = 12'd27;
    localparam logic [LED_W-1:0]  RST_LED_COUNT   = 8'd32;
    localparam logic              RST_PIN_INVERT  = 1'b1;

    // Bit within a byte that ends it
    localparam logic [2:0] LAST_BIT = 3'd7;

    // Configuration register bank as seen by the core
    typedef struct packed {
        logic [TICK_W-1:0] zero_active;
        logic [TICK_W-1:0] zero_idle;
        logic [TICK_W-1:0] one_active;
        logic [TICK_W-1:0] one_idle;
        logic [LED_W-1:0]  led_count;
        logic              pin_invert;
    } cfg_t;

    // Result of one tick
    typedef struct packed {
        logic pin_level;
        logic busy;
        logic done;
    } tick_out_t;

endpackage

// ===== sv/lsffe_cfg.sv =====
`timescale 1ns / 1ps
// Configuration register bank for the LED strip fill frame encoder.
// Depends on lsffe_pkg.
module lsffe_cfg
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [lsffe_pkg::INDEX_W-1:0] cfg_index,
    input  logic [lsffe_pkg::DATA_W-1:0]  cfg_data,
    output lsffe_pkg::cfg_t               cfg
);

    lsffe_pkg::cfg_t cfg_reg;
    lsffe_pkg::cfg_t cfg_next;

    // Decode a register write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                lsffe_pkg::REG_ZERO_ACTIVE: cfg_next.zero_active = cfg_data;
                lsffe_pkg::REG_ZERO_IDLE:   cfg_next.zero_idle   = cfg_data;
                lsffe_pkg::REG_ONE_ACTIVE:  cfg_next.one_active  = cfg_data;
                lsffe_pkg::REG_ONE_IDLE:    cfg_next.one_idle    = cfg_data;
                lsffe_pkg::REG_LED_COUNT:
                    cfg_next.led_count = cfg_data[lsffe_pkg::LED_W-1:0];
                lsffe_pkg::REG_PIN_INVERT:  cfg_next.pin_invert  = cfg_data[0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.zero_active <= lsffe_pkg::RST_ZERO_ACTIVE;
            cfg_reg.zero_idle   <= lsffe_pkg::RST_ZERO_IDLE;
            cfg_reg.one_active  <= lsffe_pkg::RST_ONE_ACTIVE;
            cfg_reg.one_idle    <= lsffe_pkg::RST_ONE_IDLE;
            cfg_reg.led_count   <= lsffe_pkg::RST_LED_COUNT;
            cfg_reg.pin_invert  <= lsffe_pkg::RST_PIN_INVERT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/lsffe_core.sv =====
`timescale 1ns / 1ps
// Frame sequencer: bit timing, byte/bit position and lit/unlit decision.
// Depends on lsffe_pkg.
module lsffe_core
#(
    parameter int unsigned MAX_LEDS = 255
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic                        start_req,
    input  logic [lsffe_pkg::LED_W-1:0] fill_count,
    input  logic                        lit_from_top,
    input  lsffe_pkg::cfg_t             cfg,
    output lsffe_pkg::tick_out_t        tick_out
);

    localparam int unsigned BW    = $clog2(3 * MAX_LEDS + 1);
    localparam int unsigned CW    = lsffe_pkg::CMP_W;
    localparam int unsigned TW    = lsffe_pkg::TICK_W;
    localparam int unsigned LW    = lsffe_pkg::LED_W;
    localparam int unsigned NW    = 10;
    localparam logic [NW-1:0] MAX_N = NW'(MAX_LEDS);

    logic            sending_reg,   sending_next;
    logic [BW-1:0]   byte_reg,      byte_next;
    logic [2:0]      bit_reg,       bit_next;
    logic            idle_ph_reg,   idle_ph_next;
    logic [TW-1:0]   ticks_reg,     ticks_next;
    logic [LW-1:0]   fill_reg,      fill_next;
    logic            dir_reg,       dir_next;

    // Values after a possible start on this tick
    logic            take_start;
    logic            eff_sending;
    logic [BW-1:0]   eff_byte;
    logic [2:0]      eff_bit;
    logic            eff_idle_ph;
    logic [TW-1:0]   eff_ticks;
    logic [LW-1:0]   eff_fill;
    logic            eff_dir;

    logic [NW-1:0]   led_n;
    logic [CW-1:0]   frame_len;
    logic [CW-1:0]   fill_bytes;
    logic [CW-1:0]   byte_ext;
    logic [CW-1:0]   byte_inc;
    logic            lit;
    logic [TW-1:0]   raw_limit;
    logic [TW-1:0]   limit;
    logic [TW:0]     spent;
    logic            phase_end;
    logic            idle_level;

    // Latch the request when idle
    assign take_start  = !sending_reg && start_req;
    assign eff_sending = sending_reg || start_req;
    assign eff_byte    = take_start ? '0 : byte_reg;
    assign eff_bit     = take_start ? '0 : bit_reg;
    assign eff_idle_ph = take_start ? 1'b0 : idle_ph_reg;
    assign eff_ticks   = take_start ? '0 : ticks_reg;
    assign eff_fill    = take_start ? fill_count : fill_reg;
    assign eff_dir     = take_start ? lit_from_top : dir_reg;

    // Clamp the LED count and size the frame
    always_comb
    begin
        led_n = NW'(cfg.led_count);
        if (led_n == '0)
        begin
            led_n = NW'(1);
        end
        if (led_n > MAX_N)
        begin
            led_n = MAX_N;
        end
    end

    assign frame_len  = CW'(led_n) * CW'(3);
    assign fill_bytes = CW'(eff_fill) * CW'(3);
    assign byte_ext   = CW'(eff_byte);
    assign byte_inc   = byte_ext + CW'(1);

    // Every bit of a lit byte is one, every bit of a dark byte zero
    assign lit = (byte_ext < fill_bytes) != eff_dir;

    // Phase length for the current bit and phase
    always_comb
    begin
        if (eff_idle_ph)
        begin
            raw_limit = lit ? cfg.one_idle : cfg.zero_idle;
        end
        else
        begin
            raw_limit = lit ? cfg.one_active : cfg.zero_active;
        end
        limit = (raw_limit == '0) ? TW'(1) : raw_limit;
    end

    assign spent      = {1'b0, eff_ticks} + (TW+1)'(1);
    assign phase_end  = spent >= {1'b0, limit};
    assign idle_level = cfg.pin_invert;

    // Advance the sequencer
    always_comb
    begin
        sending_next = eff_sending;
        byte_next    = eff_byte;
        bit_next     = eff_bit;
        idle_ph_next = eff_idle_ph;
        ticks_next   = eff_ticks;
        fill_next    = eff_fill;
        dir_next     = eff_dir;
        tick_out.pin_level = idle_level;
        tick_out.busy      = 1'b0;
        tick_out.done      = 1'b0;
        if (eff_sending)
        begin
            tick_out.busy = 1'b1;
            if (!eff_idle_ph)
            begin
                tick_out.pin_level = !idle_level;
                if (phase_end)
                begin
                    idle_ph_next = 1'b1;
                    ticks_next   = '0;
                end
                else
                begin
                    ticks_next = spent[TW-1:0];
                end
            end
            else
            begin
                if (phase_end)
                begin
                    idle_ph_next = 1'b0;
                    ticks_next   = '0;
                    if (eff_bit == lsffe_pkg::LAST_BIT)
                    begin
                        bit_next = '0;
                        if (byte_inc >= frame_len)
                        begin
                            tick_out.done = 1'b1;
                            sending_next  = 1'b0;
                            byte_next     = '0;
                        end
                        else
                        begin
                            byte_next = byte_inc[BW-1:0];
                        end
                    end
                    else
                    begin
                        bit_next = eff_bit + 3'd1;
                    end
                end
                else
                begin
                    ticks_next = spent[TW-1:0];
                end
            end
        end
    end

    // Update state once per processed tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sending_reg <= 1'b0;
            byte_reg    <= '0;
            bit_reg     <= '0;
            idle_ph_reg <= 1'b0;
            ticks_reg   <= '0;
            fill_reg    <= '0;
            dir_reg     <= 1'b0;
        end
        else if (step)
        begin
            sending_reg <= sending_next;
            byte_reg    <= byte_next;
            bit_reg     <= bit_next;
            idle_ph_reg <= idle_ph_next;
            ticks_reg   <= ticks_next;
            fill_reg    <= fill_next;
            dir_reg     <= dir_next;
        end
    end

endmodule

// ===== sv/led_strip_fill_frame_encoder.sv =====
`timescale 1ns / 1ps
// LED strip fill frame encoder: one input word per timing tick, one result word each.
// Each word passes through the input register, then the result register, before its
// result word is valid; a valid result word is taken when out_stall is low.
// Throughput: one word per cycle; a stalled result holds the input register.
// Reset (rst_n, async, active low) clears the sequencer to idle and loads the
// default register values. Depends on lsffe_pkg, lsffe_cfg and lsffe_core.
module led_strip_fill_frame_encoder
#(
    parameter int unsigned MAX_LEDS = 255
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          start_req,
    input  logic [lsffe_pkg::LED_W-1:0]   fill_count,
    input  logic                          lit_from_top,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          pin_level,
    output logic                          busy_res,
    output logic                          frame_done,
    input  logic                          cfg_we,
    input  logic [lsffe_pkg::INDEX_W-1:0] cfg_index,
    input  logic [lsffe_pkg::DATA_W-1:0]  cfg_data
);

    lsffe_pkg::cfg_t      cfg;
    lsffe_pkg::tick_out_t tick_out;

    logic                        in_vld_reg;
    logic                        start_reg;
    logic [lsffe_pkg::LED_W-1:0] fill_reg;
    logic                        dir_reg;
    logic                        out_vld_reg;
    lsffe_pkg::tick_out_t        res_reg;
    logic                        advance;
    logic                        in_take;

    // Move a word forward when the result register is free or draining
    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    lsffe_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lsffe_core #(.MAX_LEDS(MAX_LEDS)) u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .start_req    (start_reg),
        .fill_count   (fill_reg),
        .lit_from_top (dir_reg),
        .cfg          (cfg),
        .tick_out     (tick_out)
    );

    // Track input and result word valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_vld_reg <= 1'b0;
            end
            if (advance)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Hold input and result payloads
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            start_reg <= start_req;
            fill_reg  <= fill_count;
            dir_reg   <= lit_from_top;
        end
        if (advance)
        begin
            res_reg <= tick_out;
        end
    end

    assign out_valid  = out_vld_reg;
    assign pin_level  = res_reg.pin_level;
    assign busy_res   = res_reg.busy;
    assign frame_done = res_reg.done;

endmodule

// ===== verif/tb_led_strip_fill_frame_encoder.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for led_strip_fill_frame_encoder: drives one timing tick per word,
// predicts pin level, busy and frame done per tick, and checks every result word in order.
// Depends on lsffe_pkg and the led_strip_fill_frame_encoder top level.
module tb_led_strip_fill_frame_encoder;

    localparam int unsigned STRIP_MAX_LEDS = 255;
    localparam int unsigned CYCLE_LIMIT    = 1000000;
    // Indexes past the register list; writes to them must change nothing
    localparam logic [lsffe_pkg::INDEX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [lsffe_pkg::INDEX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef enum logic {STEP_WORD, STEP_REG} step_kind_t;

    typedef struct packed {
        step_kind_t                    kind;
        logic                          start;
        logic [lsffe_pkg::LED_W-1:0]   fill;
        logic                          dir;
        logic [lsffe_pkg::INDEX_W-1:0] reg_idx;
        logic [lsffe_pkg::DATA_W-1:0]  reg_val;
        logic                          fixed;
        logic                          pin;
        logic                          busy;
        logic                          done;
    } step_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic                          start_req;
    logic [lsffe_pkg::LED_W-1:0]   fill_count;
    logic                          lit_from_top;
    logic                          out_valid;
    logic                          out_stall;
    logic                          pin_level;
    logic                          busy_res;
    logic                          frame_done;
    logic                          cfg_we;
    logic [lsffe_pkg::INDEX_W-1:0] cfg_index;
    logic [lsffe_pkg::DATA_W-1:0]  cfg_data;

    // Predictor state: register shadow and frame sequencer
    lsffe_pkg::cfg_t               strip_cfg;
    logic                          enc_sending;
    logic [9:0]                    enc_byte;
    logic [2:0]                    enc_bit;
    logic                          enc_idle_phase;
    logic [lsffe_pkg::TICK_W-1:0]  enc_phase_ticks;
    logic [lsffe_pkg::LED_W-1:0]   enc_fill;
    logic                          enc_dir;

    lsffe_pkg::tick_out_t          tick_levels_q[$];
    int                            mismatches = 0;
    int unsigned                   cycle_count = 0;
    int unsigned                   stall_left = 0;
    logic                          gaps_on = 1'b1;

    // Directed words and register writes; typed results only where obvious
    step_t directed_steps [21] = '{
        '{STEP_WORD, 1'b0, 8'd0, 1'b0, lsffe_pkg::REG_ZERO_ACTIVE, 12'd0, 1'b1, 1'b1, 1'b0, 1'b0},
        '{STEP_WORD, 1'b0, 8'd255, 1'b1, lsffe_pkg::REG_ZERO_ACTIVE, 12'd0, 1'b1, 1'b1, 1'b0, 1'b0},
        '{STEP_WORD, 1'b1, 8'd255, 1'b0, lsffe_pkg::REG_ZERO_ACTIVE, 12'd0, 1'b1, 1'b0, 1'b1, 1'b0},
        '{STEP_WORD, 1'b1, 8'd0, 1'b1, lsffe_pkg::REG_ZERO_ACTIVE, 12'd0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{STEP_REG, 1'b0, 8'd0, 1'b0, lsffe_pkg::REG_PIN_INVERT, 12'd0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{STEP_WORD, 1'b0, 8'd0, 1'b0, lsffe_pkg::REG_ZERO_ACTIVE, 12'd0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{STEP_REG, 1'b0, 8'd0, 1'b0, lsffe_pkg::REG_ONE_ACTIVE, 12'd0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{STEP_WORD, 1'b0, 8'd0, 1'b0, lsffe_pkg::REG_ZERO_ACTIVE, 12'd0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{STEP_REG, 1'b0, 8'd0, 1'b0, lsffe_pkg::REG_ONE_IDLE, 12'd4095, 1'b0, 1'b0, 1'b0, 1'b0},
        '{STEP_WORD, 1'b0, 8'd170, 1'b0, lsffe_pkg::REG_ZERO_ACTIVE, 12'd0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{STEP_REG, 1'b0, 8'd0, 1'b0, lsffe_pkg::REG_LED_COUNT, 12'd0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{STEP_REG, 1'b0, 8'd0, 1'b0, lsffe_pkg::REG_ZERO_ACTIVE, 12'd4095, 1'b0, 1'b0, 1'b0, 1'b0},
        '{STEP_REG, 1'b0, 8'd0, 1'b0, lsffe_pkg::REG_ZERO_IDLE, 12'd0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{STEP_REG, 1'b0, 8'd0, 1'b0, REG_SPARE_LO, 12'd4095, 1'b0, 1'b0, 1'b0, 1'b0},
        '{STEP_REG, 1'b0, 8'd0, 1'b0, REG_SPARE_HI, 12'd4095, 1'b0, 1'b0, 1'b0, 1'b0},
        '{STEP_WORD, 1'b1, 8'd128, 1'b1, lsffe_pkg::REG_ZERO_ACTIVE, 12'd0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{STEP_REG, 1'b0, 8'd0, 1'b0, lsffe_pkg::REG_PIN_INVERT, 12'd1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{STEP_WORD, 1'b0, 8'd85, 1'b1, lsffe_pkg::REG_ZERO_ACTIVE, 12'd0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{STEP_REG, 1'b0, 8'd0, 1'b0, lsffe_pkg::REG_ONE_IDLE, 12'd0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{STEP_WORD, 1'b0, 8'd0, 1'b0, lsffe_pkg::REG_ZERO_ACTIVE, 12'd0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{STEP_WORD, 1'b0, 8'd255, 1'b0, lsffe_pkg::REG_ZERO_ACTIVE, 12'd0, 1'b0, 1'b0, 1'b0, 1'b0}
    };

    led_strip_fill_frame_encoder #(
        .MAX_LEDS(STRIP_MAX_LEDS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .start_req(start_req),
        .fill_count(fill_count),
        .lit_from_top(lit_from_top),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .pin_level(pin_level),
        .busy_res(busy_res),
        .frame_done(frame_done),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // A zero phase time still lasts one tick
    function automatic logic [lsffe_pkg::TICK_W-1:0] ticks_or_one(
        input logic [lsffe_pkg::TICK_W-1:0] t);
        return (t == '0) ? 12'd1 : t;
    endfunction

    function automatic logic [lsffe_pkg::TICK_W-1:0] draw_ticks(input logic stress);
        return stress ? 12'($urandom_range(0, 4095)) : 12'($urandom_range(0, 3));
    endfunction

    // Advance the frame sequencer by one tick and return the pin, busy and done levels
    task automatic encode_tick(input logic start, input logic [lsffe_pkg::LED_W-1:0] fill,
                               input logic dir, output lsffe_pkg::tick_out_t res);
        logic                         lit;
        logic [lsffe_pkg::TICK_W:0]   spent;
        logic [lsffe_pkg::TICK_W-1:0] span;
        int unsigned                  leds;
        leds = strip_cfg.led_count;
        if (leds == 0)
            leds = 1;
        if (leds > STRIP_MAX_LEDS)
            leds = STRIP_MAX_LEDS;
        res.pin_level = strip_cfg.pin_invert;
        res.busy      = 1'b0;
        res.done      = 1'b0;
        // Latch a new frame only when idle
        if (!enc_sending && start) begin
            enc_sending     = 1'b1;
            enc_fill        = fill;
            enc_dir         = dir;
            enc_byte        = '0;
            enc_bit         = '0;
            enc_idle_phase  = 1'b0;
            enc_phase_ticks = '0;
        end
        if (enc_sending) begin
            // Bytes are all ones or all zeros, so each bit equals the lit flag
            lit      = ((int'(enc_byte) < 3 * int'(enc_fill)) != enc_dir);
            spent    = {1'b0, enc_phase_ticks} + 13'd1;
            res.busy = 1'b1;
            if (!enc_idle_phase) begin
                span          = ticks_or_one(lit ? strip_cfg.one_active : strip_cfg.zero_active);
                res.pin_level = ~strip_cfg.pin_invert;
                if (spent >= span) begin
                    enc_idle_phase  = 1'b1;
                    enc_phase_ticks = '0;
                end
                else
                    enc_phase_ticks = spent[lsffe_pkg::TICK_W-1:0];
            end
            else begin
                span = ticks_or_one(lit ? strip_cfg.one_idle : strip_cfg.zero_idle);
                if (spent >= span) begin
                    enc_idle_phase  = 1'b0;
                    enc_phase_ticks = '0;
                    if (enc_bit == lsffe_pkg::LAST_BIT) begin
                        enc_bit = '0;
                        if (int'(enc_byte) + 1 >= 3 * leds) begin
                            res.done    = 1'b1;
                            enc_sending = 1'b0;
                            enc_byte    = '0;
                        end
                        else
                            enc_byte = enc_byte + 10'd1;
                    end
                    else
                        enc_bit = enc_bit + 3'd1;
                end
                else
                    enc_phase_ticks = spent[lsffe_pkg::TICK_W-1:0];
            end
        end
    endtask

    // Present one tick word, wait for it to be taken, and queue its expected result
    task automatic send_word(input logic start, input logic [lsffe_pkg::LED_W-1:0] fill,
                             input logic dir, input logic fixed = 1'b0,
                             input lsffe_pkg::tick_out_t typed = '0);
        lsffe_pkg::tick_out_t res;
        cfg_we <= 1'b0;
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid     <= 1'b1;
        start_req    <= start;
        fill_count   <= fill;
        lit_from_top <= dir;
        do
            @(posedge clk);
        while (in_stall);
        encode_tick(start, fill, dir, res);
        tick_levels_q.push_back(fixed ? typed : res);
        @(negedge clk);
    endtask

    // Random content; fill leans toward the lit/unlit boundary of the current strip
    task automatic send_random_word();
        logic [lsffe_pkg::LED_W-1:0] fill;
        case ($urandom_range(0, 3))
            0: fill = 8'($urandom_range(0, 255));
            1: fill = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            default: fill = 8'($urandom_range(0, int'(strip_cfg.led_count) + 1));
        endcase
        send_word($urandom_range(0, 3) == 0, fill, 1'($urandom_range(0, 1)));
    endtask

    // Keep a frame going until it ends or the word budget runs out
    task automatic run_frame_out(input int unsigned max_words);
        int unsigned n;
        n = 0;
        while (enc_sending && n < max_words) begin
            send_random_word();
            n++;
        end
    endtask

    // Hold input and wait until every queued result has come back
    task automatic drain_words();
        in_valid <= 1'b0;
        while (tick_levels_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [lsffe_pkg::INDEX_W-1:0] idx,
                             input logic [lsffe_pkg::DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            lsffe_pkg::REG_ZERO_ACTIVE: strip_cfg.zero_active = val;
            lsffe_pkg::REG_ZERO_IDLE:   strip_cfg.zero_idle   = val;
            lsffe_pkg::REG_ONE_ACTIVE:  strip_cfg.one_active  = val;
            lsffe_pkg::REG_ONE_IDLE:    strip_cfg.one_idle    = val;
            lsffe_pkg::REG_LED_COUNT:   strip_cfg.led_count   = val[lsffe_pkg::LED_W-1:0];
            lsffe_pkg::REG_PIN_INVERT:  strip_cfg.pin_invert  = val[0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Output stall in random bursts, started only while gaps are on
    always @(negedge clk)
    begin
        if (stall_left != 0) begin
            out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end
        else if (gaps_on && $urandom_range(0, 5) == 0) begin
            out_stall <= 1'b1;
            stall_left = $urandom_range(0, 3);
        end
        else
            out_stall <= 1'b0;
    end

    // Compare each taken result word with the oldest expectation
    always @(posedge clk)
    begin : check_results
        lsffe_pkg::tick_out_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (tick_levels_q.size() == 0) begin
                $error("result word with no expectation: pin_level %0b busy_res %0b frame_done %0b",
                       pin_level, busy_res, frame_done);
                mismatches++;
            end
            else begin
                want = tick_levels_q.pop_front();
                if (pin_level !== want.pin_level) begin
                    $error("pin_level: expected %0b, got %0b", want.pin_level, pin_level);
                    mismatches++;
                end
                if (busy_res !== want.busy) begin
                    $error("busy_res: expected %0b, got %0b", want.busy, busy_res);
                    mismatches++;
                end
                if (frame_done !== want.done) begin
                    $error("frame_done: expected %0b, got %0b", want.done, frame_done);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_led_strip_fill_frame_encoder: FAIL");
            $finish;
        end
    end

    initial
    begin
        int unsigned episode;
        int unsigned episode_words;
        int unsigned len;
        logic        stress;
        step_t       s;
        episode       = 0;
        episode_words = 0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        start_req     = 1'b0;
        fill_count    = '0;
        lit_from_top  = 1'b0;
        out_stall     = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        strip_cfg     = '{lsffe_pkg::RST_ZERO_ACTIVE, lsffe_pkg::RST_ZERO_IDLE,
                          lsffe_pkg::RST_ONE_ACTIVE, lsffe_pkg::RST_ONE_IDLE,
                          lsffe_pkg::RST_LED_COUNT, lsffe_pkg::RST_PIN_INVERT};
        enc_sending     = 1'b0;
        enc_byte        = '0;
        enc_bit         = '0;
        enc_idle_phase  = 1'b0;
        enc_phase_ticks = '0;
        enc_fill        = '0;
        enc_dir         = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset levels, start tick, ignored start, register changes mid-frame
        foreach (directed_steps[i]) begin
            s = directed_steps[i];
            if (s.kind == STEP_REG) begin
                drain_words();
                write_reg(s.reg_idx, s.reg_val);
            end
            else
                send_word(s.start, s.fill, s.dir, s.fixed, {s.pin, s.busy, s.done});
        end

        // Longest phases: start a frame with the top bit times and run into its first bit
        drain_words();
        write_reg(lsffe_pkg::REG_ZERO_ACTIVE, 12'd4095);
        write_reg(lsffe_pkg::REG_ZERO_IDLE, 12'd4095);
        write_reg(lsffe_pkg::REG_ONE_ACTIVE, 12'd4095);
        write_reg(lsffe_pkg::REG_ONE_IDLE, 12'd4095);
        write_reg(lsffe_pkg::REG_LED_COUNT, 12'd1);
        send_word(1'b1, 8'd255, 1'b0);
        run_frame_out(120);

        // Longest strip with the shortest bits; the running frame stretches to 765 bytes
        drain_words();
        write_reg(lsffe_pkg::REG_ZERO_ACTIVE, 12'd0);
        write_reg(lsffe_pkg::REG_ZERO_IDLE, 12'd0);
        write_reg(lsffe_pkg::REG_ONE_ACTIVE, 12'd0);
        write_reg(lsffe_pkg::REG_ONE_IDLE, 12'd0);
        write_reg(lsffe_pkg::REG_LED_COUNT, 12'hFFF);
        send_word(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        run_frame_out(120);

        // Random episodes: new settings between bursts of words, mostly short frames
        while (episode_words < 500 && episode < 200) begin
            drain_words();
            gaps_on = (episode_words < 380) && ($urandom_range(0, 3) != 0);
            stress  = ($urandom_range(0, 7) == 0);
            write_reg(lsffe_pkg::REG_ZERO_ACTIVE, draw_ticks(stress));
            write_reg(lsffe_pkg::REG_ZERO_IDLE, draw_ticks(stress));
            write_reg(lsffe_pkg::REG_ONE_ACTIVE, draw_ticks(stress));
            write_reg(lsffe_pkg::REG_ONE_IDLE, draw_ticks(stress));
            write_reg(lsffe_pkg::REG_LED_COUNT, {4'($urandom_range(0, 15)),
                      stress ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 3))});
            write_reg(lsffe_pkg::REG_PIN_INVERT, 12'($urandom_range(0, 4095)));
            if ($urandom_range(0, 9) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                          12'($urandom_range(0, 4095)));
            len = $urandom_range(20, 250);
            repeat (len) send_random_word();
            episode_words += len;
            episode++;
        end

        drain_words();
        repeat (8) @(negedge clk);
        if (mismatches == 0)
            $display("tb_led_strip_fill_frame_encoder: PASS");
        else
            $display("tb_led_strip_fill_frame_encoder: FAIL");
        $finish;
    end

endmodule
